// ===== hw/rtl/cluster_correlation_average_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Cluster correlation average: assertion macros
// Shared concurrent assertion forms used by the back-end module.
// ----------------------------------------------------------------------------
`ifndef CLUSTER_CORRELATION_AVERAGE_UNIT_ASSERT_SVH
`define CLUSTER_CORRELATION_AVERAGE_UNIT_ASSERT_SVH

// same-cycle implication
`define CCA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CCA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ccavg_pkg.sv =====
// ----------------------------------------------------------------------------
// Cluster correlation average: package
// Shared widths, queue entry type and saturation helper.
// ----------------------------------------------------------------------------
package ccavg_pkg;

  localparam int DATA_W = 32;
  localparam int SPIN_W = 4;
  localparam int POW_W  = 11;
  localparam int TERM_W = DATA_W + POW_W;
  localparam int DEGS   = 4;
  localparam int SUM_W  = 48;
  localparam int OCNT_W = 11;

  typedef struct packed {
    logic signed [DATA_W-1:0] poly;
    logic                     clip;
    logic                     last_c;
    logic                     last_o;
  } entry_t;

  // {clip, value}
  function automatic logic [DATA_W:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_0000_7FFF_FFFF;
    lo = -64'sh0000_0000_8000_0000;
    if (v > hi) begin
      sat32 = {1'b1, 32'h7FFF_FFFF};
    end else if (v < lo) begin
      sat32 = {1'b1, 32'h8000_0000};
    end else begin
      sat32 = {1'b0, v[DATA_W-1:0]};
    end
  endfunction

endpackage

// ===== hw/rtl/cluster_correlation_average_unit.sv =====
// Path per site: front registers a, b, c, the 2-entry queue, then S_IDLE, S_MUL, S_PROD;
//   a cluster end adds S_SUM, an orbit end adds the S_DIV divide and S_OUT before the result.
// Pacing: the back end pops a site only in S_IDLE, after the last site's product update;
//   the 2-entry queue lets the front keep accepting while the back divides, until it fills.
// Reset: synchronous, active high; clears all pipeline valids, product to 1.0, sum and count.
// ----------------------------------------------------------------------------
// Cluster correlation average unit
// Evaluates per-site basis polynomials, forms cluster products and emits the
// orbit average of cluster products in signed fixed point.
// ----------------------------------------------------------------------------
module cluster_correlation_average_unit #(
  parameter int MAX_CLUSTERS = 1024,
  parameter int POLY_TERMS   = 4,
  parameter int FRAC_BITS    = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [ccavg_pkg::SPIN_W-1:0] spin,
  input  logic signed [ccavg_pkg::DATA_W-1:0] coef_cubic,
  input  logic signed [ccavg_pkg::DATA_W-1:0] coef_square,
  input  logic signed [ccavg_pkg::DATA_W-1:0] coef_linear,
  input  logic signed [ccavg_pkg::DATA_W-1:0] coef_const,
  input  logic                                last_in_cluster,
  input  logic                                last_in_orbit,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ccavg_pkg::DATA_W-1:0] correlation,
  output logic [ccavg_pkg::OCNT_W-1:0]        cluster_count,
  output logic                                saturated
);

  logic              push, q_full, q_valid, q_pop;
  ccavg_pkg::entry_t push_data, q_data;

  ccavg_front #(.POLY_TERMS(POLY_TERMS)) u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .spin            (spin),
    .coef_cubic      (coef_cubic),
    .coef_square     (coef_square),
    .coef_linear     (coef_linear),
    .coef_const      (coef_const),
    .last_in_cluster (last_in_cluster),
    .last_in_orbit   (last_in_orbit),
    .push            (push),
    .push_data       (push_data),
    .q_full          (q_full)
  );

  ccavg_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (push_data),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_data)
  );

  ccavg_back #(
    .MAX_CLUSTERS (MAX_CLUSTERS),
    .FRAC_BITS    (FRAC_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_data        (q_data),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .correlation   (correlation),
    .cluster_count (cluster_count),
    .saturated     (saturated)
  );

endmodule

// ===== hw/rtl/ccavg_front.sv =====
// ----------------------------------------------------------------------------
// Cluster correlation average: front end
// Three-stage pipeline evaluating the site basis polynomial, with clipping.
// ----------------------------------------------------------------------------
module ccavg_front #(
  parameter int POLY_TERMS = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [ccavg_pkg::SPIN_W-1:0] spin,
  input  logic signed [ccavg_pkg::DATA_W-1:0] coef_cubic,
  input  logic signed [ccavg_pkg::DATA_W-1:0] coef_square,
  input  logic signed [ccavg_pkg::DATA_W-1:0] coef_linear,
  input  logic signed [ccavg_pkg::DATA_W-1:0] coef_const,
  input  logic                                last_in_cluster,
  input  logic                                last_in_orbit,
  output logic                                push,
  output ccavg_pkg::entry_t                   push_data,
  input  logic                                q_full
);

  logic signed [ccavg_pkg::DATA_W-1:0] a_coef [ccavg_pkg::DEGS];
  logic signed [ccavg_pkg::POW_W-1:0]  a_pow  [ccavg_pkg::DEGS];
  logic                                a_valid, a_lc, a_lo;
  logic signed [ccavg_pkg::TERM_W-1:0] b_term [ccavg_pkg::DEGS];
  logic                                b_valid, b_lc, b_lo;
  logic                                c_valid;
  ccavg_pkg::entry_t                   c_data;

  logic signed [ccavg_pkg::DATA_W-1:0] coef_in [ccavg_pkg::DEGS];
  logic signed [ccavg_pkg::POW_W-1:0]  pow_in  [ccavg_pkg::DEGS];
  logic signed [7:0]                   s2;
  logic signed [ccavg_pkg::POW_W-1:0]  s3;
  logic signed [63:0]                  acc;
  logic [ccavg_pkg::DATA_W:0]          acc_sat;
  logic                                adv;

  assign adv      = !c_valid || !q_full;
  assign in_stall = !adv;
  assign push      = c_valid && !q_full;
  assign push_data = c_data;

  assign s2 = 8'(spin) * 8'(spin);
  assign s3 = ccavg_pkg::POW_W'(s2) * ccavg_pkg::POW_W'(spin);

  always_comb begin
    pow_in[0]  = ccavg_pkg::POW_W'(1);
    pow_in[1]  = ccavg_pkg::POW_W'(spin);
    pow_in[2]  = ccavg_pkg::POW_W'(s2);
    pow_in[3]  = s3;
    coef_in[0] = coef_const;
    coef_in[1] = coef_linear;
    coef_in[2] = coef_square;
    coef_in[3] = coef_cubic;
    // degrees at or above POLY_TERMS drop out
    for (int d = 0; d < ccavg_pkg::DEGS; d++) begin
      if (d >= POLY_TERMS) begin
        coef_in[d] = '0;
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int d = 0; d < ccavg_pkg::DEGS; d++) begin
      acc = acc + 64'(b_term[d]);
    end
  end
  assign acc_sat = ccavg_pkg::sat32(acc);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int d = 0; d < ccavg_pkg::DEGS; d++) begin
        a_coef[d] <= coef_in[d];
        a_pow[d]  <= pow_in[d];
        b_term[d] <= ccavg_pkg::TERM_W'(a_coef[d]) * ccavg_pkg::TERM_W'(a_pow[d]);
      end
      a_lc <= last_in_cluster;
      a_lo <= last_in_orbit;
      b_lc <= a_lc;
      b_lo <= a_lo;
      c_data.poly   <= acc_sat[ccavg_pkg::DATA_W-1:0];
      c_data.clip   <= acc_sat[ccavg_pkg::DATA_W];
      c_data.last_c <= b_lc;
      c_data.last_o <= b_lo;
    end
  end

endmodule

// ===== hw/rtl/ccavg_queue.sv =====
// ----------------------------------------------------------------------------
// Cluster correlation average: decoupling queue
// Two-entry FIFO between the polynomial front end and the accumulator.
// ----------------------------------------------------------------------------
module ccavg_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ccavg_pkg::entry_t din,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output ccavg_pkg::entry_t dout
);

  ccavg_pkg::entry_t mem [2];
  logic              wr_ptr, rd_ptr;
  logic [1:0]        count;

  assign full  = count == 2'd2;
  assign valid = count != 2'd0;
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

// ===== hw/rtl/ccavg_div.sv =====
// ----------------------------------------------------------------------------
// Cluster correlation average: divider
// Restoring signed-by-unsigned divide, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ccavg_div #(
  parameter int DVS_W = 11
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [ccavg_pkg::SUM_W-1:0] dividend,
  input  logic [DVS_W-1:0]                   divisor,
  output logic                               done,
  output logic signed [ccavg_pkg::SUM_W:0]   quotient
);

  localparam int CW = $clog2(ccavg_pkg::SUM_W + 1);

  logic                        busy, neg;
  logic [CW-1:0]               steps;
  logic [ccavg_pkg::SUM_W-1:0] dvd;
  logic [DVS_W-1:0]            rem, dvs;
  logic [DVS_W:0]              rem_sh;

  assign rem_sh   = {rem, dvd[ccavg_pkg::SUM_W-1]};
  assign quotient = neg ? -$signed({1'b0, dvd}) : $signed({1'b0, dvd});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= CW'(ccavg_pkg::SUM_W);
      end else if (busy) begin
        steps <= steps - CW'(1);
        if (steps == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[ccavg_pkg::SUM_W-1];
      dvd <= dividend[ccavg_pkg::SUM_W-1] ? -dividend : dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      // remainder stays below the divisor, so the shifted value fits
      if (rem_sh >= {1'b0, dvs}) begin
        rem <= DVS_W'(rem_sh - {1'b0, dvs});
        dvd <= {dvd[ccavg_pkg::SUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DVS_W-1:0];
        dvd <= {dvd[ccavg_pkg::SUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== hw/rtl/ccavg_back.sv =====
// ----------------------------------------------------------------------------
// Cluster correlation average: back end
// Cluster product, orbit sum, cluster count and final average.
// ----------------------------------------------------------------------------
`include "cluster_correlation_average_unit_assert.svh"

module ccavg_back #(
  parameter int MAX_CLUSTERS = 1024,
  parameter int FRAC_BITS    = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_valid,
  input  ccavg_pkg::entry_t                   q_data,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ccavg_pkg::DATA_W-1:0] correlation,
  output logic [ccavg_pkg::OCNT_W-1:0]        cluster_count,
  output logic                                saturated
);

  localparam int CNT_W = $clog2(MAX_CLUSTERS + 1);
  localparam logic [ccavg_pkg::DATA_W-1:0] ONE = ccavg_pkg::DATA_W'(1) << FRAC_BITS;
  localparam logic [ccavg_pkg::SUM_W-1:0] SUM_MAX = {1'b0, {(ccavg_pkg::SUM_W-1){1'b1}}};
  localparam logic [ccavg_pkg::SUM_W-1:0] SUM_MIN = {1'b1, {(ccavg_pkg::SUM_W-1){1'b0}}};

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_PROD, S_SUM, S_DIV, S_OUT} state_t;

  state_t                              state;
  logic signed [ccavg_pkg::DATA_W-1:0] product, poly;
  logic signed [ccavg_pkg::SUM_W-1:0]  sum;
  logic [CNT_W-1:0]                    count;
  logic                                clip_flag, last_c, last_o;
  logic signed [63:0]                  prod64;
  logic signed [ccavg_pkg::SUM_W:0]    quot;
  logic                                div_start, div_done;
  logic signed [ccavg_pkg::SUM_W:0]    div_q;

  logic signed [63:0]                  shifted;
  logic [ccavg_pkg::DATA_W:0]          prod_sat, quot_sat;
  logic signed [ccavg_pkg::SUM_W:0]    sum_ext;
  logic [CNT_W+ccavg_pkg::OCNT_W-1:0]  count_ext;
  logic                                out_load;

  assign q_pop    = (state == S_IDLE) && q_valid;
  assign shifted  = prod64 >>> FRAC_BITS;
  assign prod_sat = ccavg_pkg::sat32(shifted);
  assign sum_ext  = {sum[ccavg_pkg::SUM_W-1], sum} + (ccavg_pkg::SUM_W+1)'(product);
  assign quot_sat = ccavg_pkg::sat32(64'(quot));
  assign count_ext = (CNT_W+ccavg_pkg::OCNT_W)'(count);
  assign out_load = (state == S_OUT) && (!out_valid || !out_stall);

  ccavg_div #(.DVS_W(CNT_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum),
    .divisor  (count),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      product   <= ONE;
      sum       <= '0;
      count     <= '0;
      clip_flag <= 1'b0;
      div_start <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (out_valid && !out_stall && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            poly      <= q_data.poly;
            last_c    <= q_data.last_c;
            last_o    <= q_data.last_o;
            clip_flag <= clip_flag | q_data.clip;
            state     <= S_MUL;
          end
        end
        S_MUL: begin
          prod64 <= 64'(product) * 64'(poly);
          state  <= S_PROD;
        end
        S_PROD: begin
          product   <= prod_sat[ccavg_pkg::DATA_W-1:0];
          clip_flag <= clip_flag | prod_sat[ccavg_pkg::DATA_W];
          state     <= last_c ? S_SUM : S_IDLE;
        end
        S_SUM: begin
          // cluster beyond capacity is dropped and flagged
          if (count >= CNT_W'(MAX_CLUSTERS)) begin
            clip_flag <= 1'b1;
          end else begin
            count <= count + CNT_W'(1);
            if (sum_ext[ccavg_pkg::SUM_W] != sum_ext[ccavg_pkg::SUM_W-1]) begin
              sum       <= sum_ext[ccavg_pkg::SUM_W] ? SUM_MIN : SUM_MAX;
              clip_flag <= 1'b1;
            end else begin
              sum <= sum_ext[ccavg_pkg::SUM_W-1:0];
            end
          end
          product <= ONE;
          if (last_o) begin
            div_start <= 1'b1;
            state     <= S_DIV;
          end else begin
            state <= S_IDLE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            quot  <= div_q;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            correlation   <= quot_sat[ccavg_pkg::DATA_W-1:0];
            cluster_count <= count_ext[ccavg_pkg::OCNT_W-1:0];
            saturated     <= clip_flag | quot_sat[ccavg_pkg::DATA_W];
            out_valid     <= 1'b1;
            product       <= ONE;
            sum           <= '0;
            count         <= '0;
            clip_flag     <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CCA_ASSERT_IMP(a_count_max, clk, rst, 1'b1, count <= CNT_W'(MAX_CLUSTERS), "count over max")
  `CCA_ASSERT_IMP(a_pop_idle, clk, rst, q_pop, (state == S_IDLE) && q_valid, "pop outside idle")
  `CCA_ASSERT_NXT(a_orbit_clear, clk, rst, out_load, (count == '0) && (sum == '0) && (product == ONE), "orbit state not cleared")

endmodule
